// File: hw/rtl/csp_pkg.sv
package csp_pkg;

    // Parser modes.
    localparam logic [2:0] MODE_LEAD     = 3'd0;
    localparam logic [2:0] MODE_HEX      = 3'd1;
    localparam logic [2:0] MODE_DEC      = 3'd2;
    localparam logic [2:0] MODE_HEX_DONE = 3'd3;
    localparam logic [2:0] MODE_DEC_DONE = 3'd4;

    // Characters the parser reacts to.
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [3:0]  HEX_DIGITS_MAX  = 4'd8;
    localparam logic [3:0]  HEX_DIGITS_RGB  = 4'd6;
    localparam logic [2:0]  PARTS_MAX       = 3'd4;
    localparam logic [2:0]  PARTS_MIN       = 3'd3;
    localparam logic [7:0]  BYTE_MAX        = 8'd255;
    localparam logic [11:0] DEC_RADIX       = 12'd10;
    localparam logic [31:0] ALPHA_OPAQUE    = 32'hFF00_0000;

    typedef logic [7:0] byte_t;

    // Complete parser state for one string.
    typedef struct packed {
        logic [2:0]       mode;
        logic [31:0]      hex_acc;
        logic [3:0]       hex_cnt;
        logic [7:0]       part_val;
        logic             started;
        byte_t [3:0]      store;
        logic [2:0]       count;
        logic             ended;
    } csp_state_t;

    // Store slot 3 is alpha and defaults to opaque.
    localparam csp_state_t CSP_STATE_RESET = '{
        mode:     MODE_LEAD,
        hex_acc:  32'd0,
        hex_cnt:  4'd0,
        part_val: 8'd0,
        started:  1'b0,
        store:    {BYTE_MAX, 8'd0, 8'd0, 8'd0},
        count:    3'd0,
        ended:    1'b0
    };

    // Close the current decimal part, storing it if a slot is left.
    function automatic csp_state_t commit_part(csp_state_t s);
        csp_state_t r;
        r = s;
        if (s.count < PARTS_MAX)
        begin
            r.store[s.count[1:0]] = s.part_val;
            r.count = s.count + 3'd1;
        end
        r.part_val = 8'd0;
        r.started  = 1'b0;
        return r;
    endfunction

    // Hex digit decode; valid flag in bit 4.
    function automatic logic [4:0] hex_decode(byte_t c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

endpackage

// File: hw/rtl/color_string_parser_top.sv
// Color string parser: takes a color string one character per transaction
// and returns one 32-bit ARGB word after the transaction marked last_char.
// Forms accepted are "#RRGGBB", "#AARRGGBB" and decimal "r,g,b[,a]" (alpha
// defaults to 255, parts saturate at 255), with leading blanks skipped and a
// zero character ending the string; anything malformed gives 0. The block
// takes one character every cycle unless input stalls: each character updates
// the parser state, and the result lands in an output register. While a
// result waits to be taken, input stalls; in the cycle it is taken a new
// character is accepted, so strings follow back to back when the receiver
// keeps up. The result appears in the cycle after its last character is accepted.
module color_string_parser_top
    import csp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_in,
    input  logic        last_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] color_argb
);

    csp_state_t  state_reg;
    csp_state_t  state_next;
    csp_state_t  fin;
    logic [31:0] result_reg;
    logic [31:0] result_next;
    logic        out_valid_reg;
    logic        in_fire;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // Per-character state update.
    csp_char_step u_step
    (
        .cur     (state_reg),
        .char_in (char_in),
        .nxt     (state_next)
    );

    // Final result from the state after the last character.
    always_comb
    begin
        fin = state_next;
        result_next = 32'd0;
        if (fin.mode == MODE_HEX || fin.mode == MODE_HEX_DONE)
        begin
            if (fin.hex_cnt == HEX_DIGITS_RGB)
                result_next = ALPHA_OPAQUE | fin.hex_acc;
            else if (fin.hex_cnt == HEX_DIGITS_MAX)
                result_next = fin.hex_acc;
        end
        else if (fin.mode == MODE_DEC || fin.mode == MODE_DEC_DONE)
        begin
            if (fin.mode == MODE_DEC && fin.started && !fin.ended)
                fin = commit_part(fin);
            if (fin.count >= PARTS_MIN)
                result_next = {fin.store[3], fin.store[0], fin.store[1], fin.store[2]};
        end
    end

    // Parser state: back to reset after each string.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= CSP_STATE_RESET;
        else if (in_fire)
            state_reg <= last_char ? CSP_STATE_RESET : state_next;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire && last_char)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && last_char)
            result_reg <= result_next;
    end

    assign out_valid  = out_valid_reg;
    assign color_argb = result_reg;

    // A result only appears after a last character was accepted.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid && in_ready && last_char))
        else $error("result without a last character");

    // A last character always produces a result next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last_char) |=> out_valid_reg)
        else $error("last character produced no result");

    // The parser starts clean after each string.
    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last_char) |=>
            (state_reg.mode == MODE_LEAD && state_reg.count == 3'd0
             && !state_reg.ended && state_reg.hex_cnt == 4'd0))
        else $error("parser state not cleared after string");

endmodule

// File: hw/rtl/csp_char_step.sv
// Next-state logic for one character of the color string.
module csp_char_step
    import csp_pkg::*;
(
    input  csp_state_t  cur,
    input  logic [7:0]  char_in,
    output csp_state_t  nxt
);

    logic        is_digit;
    logic [11:0] dec_sum;
    logic [7:0]  dec_sat;
    logic [4:0]  hex_d;

    // Saturating decimal accumulate.
    assign is_digit = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
    assign dec_sum  = {4'd0, cur.part_val} * DEC_RADIX + {8'd0, char_in[3:0]};
    assign dec_sat  = (dec_sum > {4'd0, BYTE_MAX}) ? BYTE_MAX : dec_sum[7:0];
    assign hex_d    = hex_decode(char_in);

    always_comb
    begin
        csp_state_t s;
        logic       dec_take;
        s = cur;
        dec_take = 1'b0;
        if (!cur.ended)
        begin
            if (char_in == CHAR_NUL)
            begin
                // End of string commits an open decimal part.
                if (cur.mode == MODE_DEC && cur.started)
                    s = commit_part(s);
                s.ended = 1'b1;
            end
            else
            begin
                case (cur.mode)
                    MODE_LEAD:
                    begin
                        if (char_in == CHAR_HASH)
                            s.mode = MODE_HEX;
                        else if (char_in != CHAR_SPACE && char_in != CHAR_TAB)
                        begin
                            s.mode = MODE_DEC;
                            dec_take = 1'b1;
                        end
                    end
                    MODE_HEX:
                    begin
                        if (cur.hex_cnt < HEX_DIGITS_MAX)
                        begin
                            if (!hex_d[4])
                                s.mode = MODE_HEX_DONE;
                            else
                            begin
                                s.hex_acc = {cur.hex_acc[27:0], hex_d[3:0]};
                                s.hex_cnt = cur.hex_cnt + 4'd1;
                            end
                        end
                    end
                    MODE_DEC:
                        dec_take = 1'b1;
                    default:
                        ;
                endcase

                // Decimal character handling.
                if (dec_take)
                begin
                    if (is_digit)
                    begin
                        s.part_val = dec_sat;
                        s.started  = 1'b1;
                    end
                    else
                    begin
                        s = commit_part(s);
                        if (char_in != CHAR_COMMA || s.count >= PARTS_MAX)
                            s.mode = MODE_DEC_DONE;
                    end
                end
            end
        end
        nxt = s;
    end

endmodule

// File: sim/tb_color_string_parser_top.sv
module tb_color_string_parser_top;
    import csp_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 7;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_CHARS  = 300;
    localparam int DRAIN_CYCLES  = 4;
    localparam int REPORT_LIMIT  = 10;

    // Letters that count as hex digits; the package only names the decimal ones.
    localparam byte_t CHAR_LOWER_A = 8'h61;
    localparam byte_t CHAR_LOWER_F = 8'h66;
    localparam byte_t CHAR_UPPER_A = 8'h41;
    localparam byte_t CHAR_UPPER_F = 8'h46;

    // Predicts the parser colors and checks them against the output transactions.
    class color_scoreboard;
        logic [2:0]  mode;
        logic [31:0] hex_acc;
        logic [3:0]  hex_cnt;
        logic [8:0]  part_val;
        logic        started;
        byte_t       store [4];
        logic [2:0]  count;
        logic        ended;

        logic [31:0] colors_due [$];
        int errors;
        int strings;
        int chars;
        int hex_colors;
        int dec_colors;
        int rejected;

        function new();
            errors = 0;
            strings = 0;
            chars = 0;
            hex_colors = 0;
            dec_colors = 0;
            rejected = 0;
            clear();
        endfunction

        function void clear();
            mode = MODE_LEAD;
            hex_acc = '0;
            hex_cnt = '0;
            part_val = '0;
            started = 1'b0;
            store[0] = 8'd0;
            store[1] = 8'd0;
            store[2] = 8'd0;
            store[3] = BYTE_MAX;
            count = '0;
            ended = 1'b0;
        endfunction

        // Close the open decimal part into the next free slot.
        function void commit();
            if (count < PARTS_MAX)
            begin
                store[count[1:0]] = (part_val > BYTE_MAX) ? BYTE_MAX : part_val[7:0];
                count = count + 3'd1;
            end
            part_val = '0;
            started = 1'b0;
        endfunction

        function int hex_nibble(byte_t c);
            if (c >= CHAR_ZERO && c <= CHAR_NINE)
                return int'(c) - int'(CHAR_ZERO);
            if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F)
                return int'(c) - int'(CHAR_LOWER_A) + 10;
            if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
                return int'(c) - int'(CHAR_UPPER_A) + 10;
            return -1;
        endfunction

        function void dec_char(byte_t c);
            int v;
            if (c >= CHAR_ZERO && c <= CHAR_NINE)
            begin
                v = int'(part_val) * int'(DEC_RADIX) + int'(c) - int'(CHAR_ZERO);
                part_val = (v > int'(BYTE_MAX)) ? 9'(BYTE_MAX) : 9'(v);
                started = 1'b1;
            end
            else if (c == CHAR_COMMA)
            begin
                commit();
                if (count >= PARTS_MAX)
                    mode = MODE_DEC_DONE;
            end
            else
            begin
                commit();
                mode = MODE_DEC_DONE;
            end
        endfunction

        // Advance the predicted parser by one accepted character.
        function void note_char(byte_t c, logic last);
            int nib;
            logic [31:0] color;
            chars++;
            if (!ended)
            begin
                if (c == CHAR_NUL)
                begin
                    if (mode == MODE_DEC && started)
                        commit();
                    ended = 1'b1;
                end
                else
                begin
                    case (mode)
                        MODE_LEAD:
                        begin
                            if (c == CHAR_HASH)
                                mode = MODE_HEX;
                            else if (c != CHAR_SPACE && c != CHAR_TAB)
                            begin
                                mode = MODE_DEC;
                                dec_char(c);
                            end
                        end
                        MODE_HEX:
                        begin
                            if (hex_cnt < HEX_DIGITS_MAX)
                            begin
                                nib = hex_nibble(c);
                                if (nib < 0)
                                    mode = MODE_HEX_DONE;
                                else
                                begin
                                    hex_acc = {hex_acc[27:0], 4'(nib)};
                                    hex_cnt = hex_cnt + 4'd1;
                                end
                            end
                        end
                        MODE_DEC:
                            dec_char(c);
                        default:
                        begin
                        end
                    endcase
                end
            end
            if (last)
            begin
                color = '0;
                if (mode == MODE_HEX || mode == MODE_HEX_DONE)
                begin
                    if (hex_cnt == HEX_DIGITS_RGB)
                        color = ALPHA_OPAQUE | hex_acc;
                    else if (hex_cnt == HEX_DIGITS_MAX)
                        color = hex_acc;
                    if (color != 0)
                        hex_colors++;
                end
                else if (mode == MODE_DEC || mode == MODE_DEC_DONE)
                begin
                    if (mode == MODE_DEC && started && !ended)
                        commit();
                    if (count >= PARTS_MIN)
                    begin
                        color = {store[3], store[0], store[1], store[2]};
                        dec_colors++;
                    end
                end
                if (color == 0)
                    rejected++;
                strings++;
                colors_due.push_back(color);
                clear();
            end
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("%s", msg);
        endfunction

        // Compare one output transaction with the oldest predicted color.
        function void check_color(logic [31:0] actual);
            logic [31:0] want;
            if (colors_due.size() == 0)
                report($sformatf("unexpected color_argb %08h with nothing pending", actual));
            else
            begin
                want = colors_due.pop_front();
                if (actual !== want)
                    report($sformatf("color_argb mismatch: expected %08h, got %08h",
                                     want, actual));
            end
        endfunction

        function int pending();
            return colors_due.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  char_in;
    logic        last_char;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] color_argb;

    color_scoreboard sb;
    byte_t line_q [$];
    int send_idle_pct;
    int recv_idle_pct;
    int random_chars;
    int cycle_count;
    string hex_set;

    color_string_parser_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_in    (char_in),
        .last_char  (last_char),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .color_argb (color_argb)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    // Run limit in case the handshake hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[color_string_parser_top] ERROR");
            $finish;
        end
    end

    // Receiver back-pressure.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Output monitor: every accepted transaction is checked.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_color(color_argb);
    end

    // Present one character and hold it until the block accepts it.
    task automatic send_char(byte_t c, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_in   <= c;
        last_char <= last;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        sb.note_char(c, last);
    endtask

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_q.push_back(byte_t'(s[i]));
    endfunction

    // Send the buffered string, marking its final character.
    task automatic flush_line();
        for (int i = 0; i < line_q.size(); i++)
            send_char(line_q[i], i == line_q.size() - 1);
        line_q.delete();
    endtask

    function automatic void add_blanks();
        int n;
        n = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n)
            line_q.push_back($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
    endfunction

    function automatic void add_noise(int lo, int hi);
        repeat ($urandom_range(lo, hi))
            line_q.push_back(byte_t'($urandom_range(255)));
    endfunction

    // Optional end of a well-formed body: stray characters or a zero with junk.
    function automatic void add_tail();
        case ($urandom_range(5))
            0: add_noise(1, 1);
            1:
            begin
                line_q.push_back(CHAR_NUL);
                add_noise(0, 3);
            end
            2: add_noise(1, 4);
            default:
            begin
            end
        endcase
    endfunction

    // Build one random string, mostly well-formed hex or decimal colors.
    function automatic void build_random_line();
        int kind;
        int ndig;
        int nparts;
        kind = $urandom_range(9);
        if (kind <= 3)
        begin
            add_blanks();
            line_q.push_back(CHAR_HASH);
            case ($urandom_range(3))
                0: ndig = 6;
                1: ndig = 8;
                default: ndig = $urandom_range(0, 10);
            endcase
            repeat (ndig)
                line_q.push_back(byte_t'(hex_set[$urandom_range(21)]));
            add_tail();
        end
        else if (kind <= 7)
        begin
            add_blanks();
            nparts = ($urandom_range(2) == 0) ? $urandom_range(1, 5) : $urandom_range(3, 4);
            for (int p = 0; p < nparts; p++)
            begin
                if (p != 0)
                    line_q.push_back(CHAR_COMMA);
                ndig = ($urandom_range(9) == 0) ? $urandom_range(0, 5) : $urandom_range(1, 3);
                repeat (ndig)
                    line_q.push_back(CHAR_ZERO + byte_t'($urandom_range(9)));
            end
            if ($urandom_range(7) == 0)
                line_q.push_back(CHAR_COMMA);
            add_tail();
        end
        else if (kind == 8)
            add_noise(1, 6);
        else
        begin
            add_blanks();
            if ($urandom_range(1))
                line_q.push_back(CHAR_NUL);
        end
        if (line_q.size() == 0)
            line_q.push_back($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
    endfunction

    initial
    begin
        sb = new();
        hex_set = "0123456789abcdefABCDEF";
        cycle_count = 0;
        random_chars = 0;
        send_idle_pct = 28;
        recv_idle_pct = 63;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        char_in   <= CHAR_NUL;
        last_char <= 1'b0;
        out_ready <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings: both hex lengths, digit overflow and early stop,
        // decimal saturation, empty and trailing parts, stray characters,
        // an early zero, empty and blank strings, and the top character code.
        add_text("#1a2B3c");          flush_line();
        add_text(" \t#80FfEe0D");     flush_line();
        add_text("#12345");           flush_line();
        add_text("#123456789");       flush_line();
        add_text("#12G45");           flush_line();
        add_text("300,07,255,9,5");   flush_line();
        add_text(",2,3");             flush_line();
        add_text("1,2,");             flush_line();
        add_text("4,5,6x7");          flush_line();
        add_text("1,2,3");
        line_q.push_back(CHAR_NUL);
        add_text("9z");               flush_line();
        line_q.push_back(CHAR_NUL);   flush_line();
        add_text(" \t");              flush_line();
        line_q.push_back(8'hFF);      flush_line();

        // Random strings under three idle mixes.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 28;
                    recv_idle_pct = 63;
                end
                1:
                begin
                    send_idle_pct = 63;
                    recv_idle_pct = 28;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            while (random_chars < (phase + 1) * RANDOM_CHARS)
            begin
                build_random_line();
                random_chars += line_q.size();
                flush_line();
            end
        end
        in_valid <= 1'b0;

        // Drain outstanding colors, then allow the output register to settle.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d strings in %0d characters under three idle mixes.",
                 sb.strings, sb.chars);
        $display("Colors seen: %0d hex, %0d decimal, %0d rejected; %0d mismatches.",
                 sb.hex_colors, sb.dec_colors, sb.rejected, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[color_string_parser_top] OK");
        else
            $display("[color_string_parser_top] ERROR");
        $finish;
    end

endmodule

// File: color_string_parser_top.f
hw/rtl/csp_pkg.sv
hw/rtl/csp_char_step.sv
hw/rtl/color_string_parser_top.sv
sim/tb_color_string_parser_top.sv
